/* rtl/restricted_circular_deque_unit_defines.svh */
// assertion macros shared by the deque rtl
`ifndef RESTRICTED_CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define RESTRICTED_CIRCULAR_DEQUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication under asynchronous active-low reset
`define RCD_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication under asynchronous active-low reset
`define RCD_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("deque check failed");

`else

`define RCD_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons)
`define RCD_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)

`endif

`endif

/* rtl/rcd_pkg.sv */
// types and constants shared by the deque rtl
`timescale 1ns / 1ps

package rcd_pkg;

    // operation codes carried by each input beat
    typedef enum logic [1:0] {
        MODE_INS_REAR  = 2'd0,
        MODE_INS_FRONT = 2'd1,
        MODE_DEL_FRONT = 2'd2,
        MODE_DEL_REAR  = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_REFUSED   = 2'd3
    } status_t;

    // restriction register codes
    localparam logic RESTR_INPUT  = 1'b0;
    localparam logic RESTR_OUTPUT = 1'b1;

    // register indexes on the config port
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_RESTRICTION = 1'b1;

    // fixed field widths
    localparam int FIELD_W = 32;
    localparam int CAP_W   = 5;
    localparam int OCC_W   = 5;
    localparam int ADDR_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // decision of the control unit for one operation
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        status_t status;
    } rcd_op_t;

endpackage

/* rtl/rcd_slot_ram.sv */
// slot storage: single-port synchronous ram with registered read data
`timescale 1ns / 1ps

module rcd_slot_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  rcd_pkg::rcd_op_t         op,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    output logic [DATA_WIDTH-1:0]    rdata
);
    import rcd_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (op.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (op.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rcd_ctrl.sv */
// deque control: head, tail and count, status decision and slot address
`timescale 1ns / 1ps

module rcd_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  rcd_pkg::mode_t                  mode,
    input  logic [rcd_pkg::CAP_W-1:0]       capacity,
    input  logic                            restriction,
    output rcd_pkg::rcd_op_t                op,
    output logic [$clog2(DEPTH)-1:0]        addr,
    output logic [$clog2(DEPTH+1)-1:0]      held_count
);
    import rcd_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] count_ext;
    logic [AW-1:0]    head_inc, head_dec, tail_inc, tail_dec;
    logic             refused, full, empty;

    // ring neighbors
    always_comb
    begin
        head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
        tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        tail_dec = (tail_reg == '0) ? LAST : tail_reg - 1'b1;
    end

    // capacity clamped to 1..DEPTH, full and empty flags
    always_comb
    begin
        cap_ext   = CMP_W'(capacity);
        count_ext = CMP_W'(count_reg);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(DEPTH))
        begin
            eff_cap = CMP_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        full  = (count_ext >= eff_cap);
        empty = (count_reg == '0);
    end

    // restriction mode check
    assign refused = ((mode == MODE_INS_FRONT) && (restriction == RESTR_INPUT)) ||
                     ((mode == MODE_DEL_REAR) && (restriction == RESTR_OUTPUT));

    // status, memory access and pointer updates
    always_comb
    begin
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        op.status  = ST_OK;
        addr       = tail_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (refused)
        begin
            op.status = ST_REFUSED;
        end
        else
        begin
            unique case (mode)
                MODE_INS_REAR:
                begin
                    addr = tail_reg;
                    if (full)
                    begin
                        op.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        op.wr_en   = accept;
                        tail_next  = tail_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_INS_FRONT:
                begin
                    addr = head_dec;
                    if (full)
                    begin
                        op.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        op.wr_en   = accept;
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_DEL_FRONT:
                begin
                    addr = head_reg;
                    if (empty)
                    begin
                        op.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        op.rd_en   = accept;
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                MODE_DEL_REAR:
                begin
                    addr = tail_dec;
                    if (empty)
                    begin
                        op.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        op.rd_en   = accept;
                        tail_next  = tail_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    op.status = ST_REFUSED;
                end
            endcase
        end
    end

    // pointer and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign held_count = count_reg;

endmodule

/* rtl/restricted_circular_deque_unit.sv */
// Restricted circular deque: a ring of DEPTH signed words in one synchronous
// slot memory, with inserts and deletes at either end. Each input beat names
// one operation and yields exactly one result beat (status, removed word,
// occupancy after the operation). One operation is handled at a time: first
// the status is decided, the head or tail moves and the slot memory is
// written or read; then, once the output register is free, the registered
// read data of the memory is picked up and the output register is loaded.
// A new beat is taken as soon as the result of the previous one has moved
// into the output register, even while that result still waits there. The
// capacity register limits the words held (0 acts as 1, values above DEPTH
// act as DEPTH); the restriction register refuses front inserts (0) or rear
// deletes (1). APB byte addresses: 0 (capacity), 4 (restriction). The user
// must write them only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`include "restricted_circular_deque_unit_defines.svh"

module restricted_circular_deque_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rcd_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      mode,
    input  logic signed [rcd_pkg::FIELD_W-1:0] insert_value,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic signed [rcd_pkg::FIELD_W-1:0] removed_value,
    output logic [rcd_pkg::OCC_W-1:0]       occupancy
);
    import rcd_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEEP_W = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;

    logic [CAP_W-1:0]      capacity_reg;
    logic                  restriction_reg;
    logic                  cfg_wr;
    logic                  reg_idx;

    logic                  in_accept;
    rcd_op_t               op;
    logic [AW-1:0]         addr;
    logic [CNT_W-1:0]      held_count;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata;

    logic                  pend_reg, pend_next;
    status_t               pend_status_reg;
    logic                  pend_rd_reg;
    logic                  load_out;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg;
    logic [FIELD_W-1:0]    removed_value_reg;
    logic [OCC_W-1:0]      occupancy_reg;

    // config register writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg    <= CAP_RESET;
            restriction_reg <= RESTR_INPUT;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CAPACITY:    capacity_reg    <= pwdata[CAP_W-1:0];
                REG_RESTRICTION: restriction_reg <= pwdata[0];
                default:         capacity_reg    <= capacity_reg;
            endcase
        end
    end

    // config register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_CAPACITY:    prdata = 32'(capacity_reg);
            REG_RESTRICTION: prdata = 32'(restriction_reg);
            default:         prdata = '0;
        endcase
    end

    // input handshake: one operation in flight
    assign in_stall  = pend_reg;
    assign in_accept = in_valid & ~in_stall;

    rcd_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .mode       (mode_t'(mode)),
        .capacity   (capacity_reg),
        .restriction(restriction_reg),
        .op         (op),
        .addr       (addr),
        .held_count (held_count)
    );

    assign wdata = DATA_WIDTH'(insert_value[KEEP_W-1:0]);

    rcd_slot_ram #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ram (
        .clk  (clk),
        .op   (op),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    // pending result waits for the read data and a free output register
    assign load_out = pend_reg & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        pend_next = pend_reg;
        if (in_accept)
        begin
            pend_next = 1'b1;
        end
        else if (load_out)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_status_reg <= op.status;
            pend_rd_reg     <= op.rd_en;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg        <= pend_status_reg;
            removed_value_reg <= pend_rd_reg ? FIELD_W'(rdata[KEEP_W-1:0]) : '0;
            occupancy_reg     <= OCC_W'(held_count);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_value_reg;
    assign occupancy     = occupancy_reg;

    // checks
    `RCD_ASSERT_NEXT(a_fail_keeps_count, clk, rst_n,
        in_accept && (op.status != ST_OK), $stable(held_count))
    `RCD_ASSERT_NEXT(a_insert_grows_count, clk, rst_n,
        op.wr_en, held_count == $past(held_count) + 1'b1)
    `RCD_ASSERT_NEXT(a_delete_shrinks_count, clk, rst_n,
        op.rd_en, held_count == $past(held_count) - 1'b1)
    `RCD_ASSERT_SAME(a_underflow_empty, clk, rst_n,
        out_valid_reg && (status_reg == ST_UNDERFLOW), occupancy_reg == '0)

endmodule
